FILE: sv/hci_uart_h4_deframer_defines.svh
// assertion macros used by the checker file
`ifndef HCI_UART_H4_DEFRAMER_DEFINES_SVH
`define HCI_UART_H4_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HUD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HUD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hud_pkg.sv
// ----------------------------------------------------------------------------
// hud_pkg
// Types and constants of the H4 UART deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hud_pkg;

  // H4 packet type bytes
  localparam logic [7:0] TYPE_EVENT = 8'h04;
  localparam logic [7:0] TYPE_ACL   = 8'h02;

  // packet kinds as emitted
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ACL   = 1'b1;

  // header positions
  localparam logic [1:0] HDR_LAST_EVENT = 2'd1;
  localparam logic [1:0] HDR_LAST_ACL   = 2'd3;
  localparam logic [1:0] HDR_LEN_LOW    = 2'd2;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  // front parser phase
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_HDR  = 2'd1,
    PH_PAY  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // one result byte with its marks
  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_kind;
    logic       first_byte;
    logic       last_byte;
    logic       oversize_error;
  } hud_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } hud_q_status_t;

endpackage

FILE: sv/hud_front.sv
// ----------------------------------------------------------------------------
// hud_front
// Accepts received bytes, tracks the H4 framing and pushes result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hud_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_stall,
  input  logic [15:0]         max_payload,
  input  hud_pkg::hud_q_status_t q_status,
  output logic                push,
  output hud_pkg::hud_item_t  push_item
);
  import hud_pkg::*;

  phase_t      phase, phase_next;
  logic        kind_reg, kind_reg_next;
  logic [1:0]  header_index, header_index_next;
  logic [7:0]  length_low, length_low_next;
  logic [15:0] bytes_left, bytes_left_next;

  logic        accept;
  logic [1:0]  hdr_last;
  logic        hdr_end;
  logic [15:0] len;
  logic        too_long;
  logic        len_zero;
  logic        count_end;

  // accept whenever the queue has room
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  // header decode
  assign hdr_last  = kind_reg ? HDR_LAST_ACL : HDR_LAST_EVENT;
  assign hdr_end   = (header_index == hdr_last);
  assign len       = kind_reg ? {in_byte, length_low} : {8'h00, in_byte};
  assign too_long  = (len > max_payload);
  assign len_zero  = (len == 16'd0);
  assign count_end = (bytes_left == 16'd1);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_TYPE: begin
          if (in_byte == TYPE_EVENT || in_byte == TYPE_ACL) phase_next = PH_HDR;
        end
        PH_HDR: begin
          if (hdr_end) begin
            priority if (too_long) phase_next = PH_SKIP;
            else if (len_zero)     phase_next = PH_TYPE;
            else                   phase_next = PH_PAY;
          end
        end
        PH_PAY, PH_SKIP: begin
          if (count_end) phase_next = PH_TYPE;
        end
        default: phase_next = PH_TYPE;
      endcase
    end
  end

  // next header and length state
  always_comb begin
    kind_reg_next     = kind_reg;
    header_index_next = header_index;
    length_low_next   = length_low;
    bytes_left_next   = bytes_left;
    if (accept) begin
      unique case (phase)
        PH_TYPE: begin
          if (in_byte == TYPE_EVENT) begin
            kind_reg_next     = KIND_EVENT;
            header_index_next = 2'd0;
          end else if (in_byte == TYPE_ACL) begin
            kind_reg_next     = KIND_ACL;
            header_index_next = 2'd0;
          end
        end
        PH_HDR: begin
          if (kind_reg && header_index == HDR_LEN_LOW) length_low_next = in_byte;
          if (hdr_end) begin
            header_index_next = 2'd0;
            bytes_left_next   = len;
          end else begin
            header_index_next = header_index + 2'd1;
          end
        end
        PH_PAY, PH_SKIP: bytes_left_next = bytes_left - 16'd1;
        default: ;
      endcase
    end
  end

  // result byte towards the queue
  always_comb begin
    push                     = 1'b0;
    push_item.out_byte       = in_byte;
    push_item.packet_kind    = kind_reg;
    push_item.first_byte     = 1'b0;
    push_item.last_byte      = 1'b0;
    push_item.oversize_error = 1'b0;
    unique case (phase)
      PH_HDR: begin
        push                     = accept;
        push_item.first_byte     = (header_index == 2'd0);
        push_item.last_byte      = hdr_end && (too_long || len_zero);
        push_item.oversize_error = hdr_end && too_long;
      end
      PH_PAY: begin
        push                = accept;
        push_item.last_byte = count_end;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      kind_reg     <= KIND_EVENT;
      header_index <= 2'd0;
      length_low   <= 8'd0;
      bytes_left   <= 16'd0;
    end else begin
      phase        <= phase_next;
      kind_reg     <= kind_reg_next;
      header_index <= header_index_next;
      length_low   <= length_low_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

FILE: sv/hud_queue.sv
// ----------------------------------------------------------------------------
// hud_queue
// Two-entry queue of result bytes between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hud_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  hud_pkg::hud_item_t     push_item,
  input  logic                   pop,
  output hud_pkg::hud_item_t     pop_item,
  output hud_pkg::hud_q_status_t status
);
  import hud_pkg::*;

  localparam int Depth = 2;

  hud_item_t  entry [Depth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign pop_item         = entry[rd_ptr];
  assign status.full      = (count == 2'(Depth));
  assign status.not_empty = (count != 2'd0);

  // payload storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/hud_back.sv
// ----------------------------------------------------------------------------
// hud_back
// Output register that drains the queue onto the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hud_back (
  input  logic                   clk,
  input  logic                   rst,
  input  hud_pkg::hud_q_status_t q_status,
  input  hud_pkg::hud_item_t     q_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   packet_kind,
  output logic                   first_byte,
  output logic                   last_byte,
  output logic                   oversize_error
);
  import hud_pkg::*;

  hud_item_t hold;

  // load when the register is empty or its transaction completes
  assign pop = q_status.not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_status.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) hold <= q_item;
  end

  assign out_byte       = hold.out_byte;
  assign packet_kind    = hold.packet_kind;
  assign first_byte     = hold.first_byte;
  assign last_byte      = hold.last_byte;
  assign oversize_error = hold.oversize_error;

endmodule

FILE: sv/hci_uart_h4_deframer.sv
// A result byte passes through the queue entry and then the output register.
// Throughput: one byte per cycle while the queue is not full.
// The output register and a two-entry queue hold up to three result bytes; once the queue
// is full the input stalls. Type bytes and skipped payload bytes produce no result.
// Reset (rst, synchronous) empties the queue and output, and sets max_payload to 1024.
// ----------------------------------------------------------------------------
// hci_uart_h4_deframer
// Cuts a received UART byte stream into HCI H4 event and ACL packets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hci_uart_h4_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        packet_kind,
  output logic        first_byte,
  output logic        last_byte,
  output logic        oversize_error
);
  import hud_pkg::*;

  logic          [15:0] max_payload;
  hud_q_status_t        q_status;
  hud_item_t            push_item, pop_item;
  logic                 push, pop;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  hud_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_byte     (in_byte),
    .in_stall    (in_stall),
    .max_payload (max_payload),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  hud_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  hud_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .q_item         (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .packet_kind    (packet_kind),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .oversize_error (oversize_error)
  );

endmodule

FILE: sv/hud_checker.sv
// ----------------------------------------------------------------------------
// hud_checker
// Port-level checks on the H4 deframer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hci_uart_h4_deframer_defines.svh"

module hud_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        first_byte,
  input logic        last_byte,
  input logic        oversize_error
);

  // a stalled result transaction holds its byte
  `HUD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled result changed")

  // an oversize flag always closes the packet
  `HUD_ASSERT_NOW(a_err_last, out_valid && oversize_error, last_byte, "oversize flag without last mark")

  // a header never ends on its first byte
  `HUD_ASSERT_NOW(a_first_not_last, out_valid && first_byte, !last_byte, "first byte also marked last")

  // with the output empty the queue cannot be full
  `HUD_ASSERT_NOW(a_no_stall_idle, !out_valid, !in_stall, "input stalled while output is empty")

endmodule

bind hci_uart_h4_deframer hud_checker u_hud_checker (.*);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the H4 UART deframer: a clocked driver sends bytes
// from a queue, an in-line framer predicts each result, and a clocked
// monitor compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hud_pkg::*;

  // framer state kept by the predictor
  typedef struct {
    phase_t      phase;
    logic        kind;
    logic [1:0]  idx;
    logic [7:0]  len_lo;
    logic [15:0] left;
  } framer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        packet_kind;
  logic        first_byte;
  logic        last_byte;
  logic        oversize_error;

  logic [7:0]  tx_bytes[$];
  hud_item_t   due_results[$];
  framer_t     rx_framer;
  framer_t     plan_framer;
  logic [15:0] max_limit = MAX_PAYLOAD_RESET;
  logic [15:0] acl_len_plan = '0;
  hud_item_t   predicted;
  hud_item_t   scratch;
  hud_item_t   want;
  int          gap_left = 0;
  int          stall_left = 0;
  int          free_left = 0;
  int          hold_left = 0;
  bit          pressure_done = 0;
  bit          idle_on = 1;
  bit          stall_on = 1;
  int          results_seen = 0;
  int          fail_count = 0;

  hci_uart_h4_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .packet_kind    (packet_kind),
    .first_byte     (first_byte),
    .last_byte      (last_byte),
    .oversize_error (oversize_error)
  );

  always #5 clk = ~clk;

  function automatic framer_t framer_at_reset();
    framer_t s;
    s.phase  = PH_TYPE;
    s.kind   = KIND_EVENT;
    s.idx    = '0;
    s.len_lo = '0;
    s.left   = '0;
    return s;
  endfunction

  // advance the framer by one byte; returns 1 when a result byte is produced
  function automatic bit frame_byte(inout framer_t s, input logic [7:0] b,
                                    input logic [15:0] limit, output hud_item_t r);
    logic [1:0]  hdr_end;
    logic [15:0] len;
    bit          got;
    r   = '0;
    got = 0;
    case (s.phase)
      PH_HDR: begin
        hdr_end = (s.kind == KIND_ACL) ? HDR_LAST_ACL : HDR_LAST_EVENT;
        if (s.kind == KIND_ACL && s.idx == HDR_LEN_LOW) s.len_lo = b;
        r.out_byte    = b;
        r.packet_kind = s.kind;
        r.first_byte  = (s.idx == 2'd0);
        got = 1;
        if (s.idx == hdr_end) begin
          len   = (s.kind == KIND_ACL) ? {b, s.len_lo} : {8'h00, b};
          s.idx = '0;
          if (len > limit) begin
            // oversize: flag on the last header byte, payload is skipped
            s.left  = len;
            s.phase = PH_SKIP;
            r.last_byte      = 1'b1;
            r.oversize_error = 1'b1;
          end else if (len == 16'd0) begin
            s.left  = '0;
            s.phase = PH_TYPE;
            r.last_byte = 1'b1;
          end else begin
            s.left  = len;
            s.phase = PH_PAY;
          end
        end else begin
          s.idx = s.idx + 2'd1;
        end
      end
      PH_PAY: begin
        s.left = s.left - 16'd1;
        r.out_byte    = b;
        r.packet_kind = s.kind;
        r.last_byte   = (s.left == 16'd0);
        if (s.left == 16'd0) s.phase = PH_TYPE;
        got = 1;
      end
      PH_SKIP: begin
        s.left = s.left - 16'd1;
        if (s.left == 16'd0) s.phase = PH_TYPE;
      end
      default: begin
        s.phase = PH_TYPE;
        if (b == TYPE_EVENT) begin
          s.kind  = KIND_EVENT;
          s.idx   = '0;
          s.phase = PH_HDR;
        end else if (b == TYPE_ACL) begin
          s.kind  = KIND_ACL;
          s.idx   = '0;
          s.phase = PH_HDR;
        end
      end
    endcase
    return got;
  endfunction

  // idle lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // payload length: mostly short, some near a small limit, a few long
  function automatic logic [15:0] choose_len(bit acl);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) v = 0;
    else if (r < 70) v = $urandom_range(1, 6);
    else if (r < 85) v = $urandom_range(7, 40);
    else if (r < 95) begin
      if (max_limit <= 16'd48) v = int'(max_limit) + int'($urandom_range(0, 2)) - 1;
      else v = $urandom_range(1, 12);
    end else begin
      v = acl ? $urandom_range(256, 300) : $urandom_range(41, 255);
    end
    if (v < 0) v = 0;
    return v[15:0];
  endfunction

  // next byte of a well-formed stream, chosen from where the sender's framer stands
  function automatic logic [7:0] pick_byte();
    logic [15:0] len;
    case (plan_framer.phase)
      PH_TYPE: begin
        if ($urandom_range(0, 99) < 88) return ($urandom_range(0, 1) != 0) ? TYPE_ACL : TYPE_EVENT;
        return 8'($urandom_range(0, 255));
      end
      PH_HDR: begin
        if (plan_framer.kind == KIND_EVENT) begin
          if (plan_framer.idx == HDR_LAST_EVENT) begin
            len = choose_len(0);
            return len[7:0];
          end
        end else if (plan_framer.idx == HDR_LEN_LOW) begin
          acl_len_plan = choose_len(1);
          return acl_len_plan[7:0];
        end else if (plan_framer.idx == HDR_LAST_ACL) begin
          return acl_len_plan[15:8];
        end
        return 8'($urandom_range(0, 255));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // queue a byte for the driver and track the framing it implies
  function automatic bit queue_byte(logic [7:0] b);
    tx_bytes.push_back(b);
    return frame_byte(plan_framer, b, max_limit, scratch);
  endfunction

  task automatic queue_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) void'(queue_byte(seq[i]));
  endtask

  // complete any packet left open so the next phase starts on a type byte
  task automatic finish_packet();
    while (plan_framer.phase != PH_TYPE) void'(queue_byte(pick_byte()));
  endtask

  task automatic send_packets(int n_bytes);
    int made;
    made = 0;
    while (made < n_bytes) begin
      void'(queue_byte(pick_byte()));
      made++;
    end
    finish_packet();
  endtask

  // everything sent and returned, then a wait for bytes that give no result
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_limit = v;
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // driver: predicts each accepted transaction, then offers the next byte
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      if (frame_byte(rx_framer, in_byte, max_limit, predicted)) due_results.push_back(predicted);
    end
    if (in_valid && in_stall) begin
      // payload held while stalled
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (tx_bytes.size() > 0) begin
      in_byte  <= tx_bytes.pop_front();
      in_valid <= 1'b1;
      gap_left <= idle_on ? gap_len() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && results_seen >= 150) begin
      out_stall     <= 1'b1;
      hold_left     <= 120;
      pressure_done <= 1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= gap_len();
      free_left  <= $urandom_range(0, 5);
    end
  end

  // monitor: each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0h", $time, out_byte);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("packet_kind", want.packet_kind, packet_kind);
        check_field("first_byte", want.first_byte, first_byte);
        check_field("last_byte", want.last_byte, last_byte);
        check_field("oversize_error", want.oversize_error, oversize_error);
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    logic [15:0] limits[6];
    rx_framer   = framer_at_reset();
    plan_framer = framer_at_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit: unknown type bytes, zero-length event, short ACL and event
    queue_seq('{8'h00, 8'hFF, TYPE_EVENT, 8'hFF, 8'h00,
                TYPE_ACL, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hA5,
                TYPE_EVENT, 8'h0E, 8'h02, 8'h00, 8'hFF});

    // small limit: length equal to the limit, oversize event and ACL with skip
    set_limit(16'd3);
    queue_seq('{TYPE_EVENT, 8'h3E, 8'h03, 8'h01, 8'h02, 8'h03,
                TYPE_EVENT, 8'h3E, 8'h04, 8'h11, 8'h22, 8'h33, 8'h44,
                TYPE_ACL, 8'h00, 8'h00, 8'h05, 8'h00});
    finish_packet();

    // zero limit: zero length still passes, high length byte oversize
    set_limit(16'd0);
    queue_seq('{TYPE_EVENT, 8'h10, 8'h00, TYPE_ACL, 8'h01, 8'h02, 8'h00, 8'h01});
    finish_packet();

    // random packets under a spread of limits, extremes included
    limits = '{16'hFFFF, 16'd0, 16'($urandom_range(1, 48)), 16'd1024,
               16'($urandom_range(0, 65535)), 16'($urandom_range(2, 20))};
    foreach (limits[i]) begin
      set_limit(limits[i]);
      idle_on  = (i % 3 != 2);
      stall_on = (i % 3 != 1);
      send_packets(120);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
